// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl files, included by ucrb_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clk edge, off while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen on a rising clk edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/ucrb_pkg.sv =====
// shared types, constants and pointer helpers for the uart ring buffers
`default_nettype none

package ucrb_pkg;

	localparam int RX_DEPTH = 256;
	localparam int TX_DEPTH = 256;
	localparam int RX_AW    = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;
	localparam int TX_AW    = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1;

	typedef logic [RX_AW-1:0] rx_ptr_t;
	typedef logic [TX_AW-1:0] tx_ptr_t;
	typedef logic [7:0]       byte_t;

	typedef enum logic [1:0] {
		KIND_HOST_WRITE = 2'd0,
		KIND_HOST_READ  = 2'd1,
		KIND_LINE_RX    = 2'd2,
		KIND_TX_READY   = 2'd3
	} kind_t;

	// one port of a ring store: a write and a read per cycle
	typedef struct packed {
		logic    we;
		rx_ptr_t waddr;
		byte_t   wdata;
		logic    re;
		rx_ptr_t raddr;
	} rx_mem_t;

	typedef struct packed {
		logic    we;
		tx_ptr_t waddr;
		byte_t   wdata;
		logic    re;
		tx_ptr_t raddr;
	} tx_mem_t;

	// status flags of one result item
	typedef struct packed {
		logic write_accepted;
		logic read_valid;
		logic tx_valid;
		logic tx_irq_enabled;
		logic tx_idle;
		logic rx_dropped;
	} res_flags_t;

	function automatic rx_ptr_t rx_next(input rx_ptr_t p);
		rx_ptr_t r;
		if (p == RX_AW'(RX_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + RX_AW'(1);
		end
		return r;
	endfunction

	function automatic tx_ptr_t tx_next(input tx_ptr_t p);
		tx_ptr_t r;
		if (p == TX_AW'(TX_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + TX_AW'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ucrb_ram.sv =====
// generic single-clock ram, one write and one registered read port
`default_nettype none

module ucrb_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ucrb_ctrl.sv =====
// ring pointers, transmit enable and store access commands
`default_nettype none

`include "assert_macros.svh"

module ucrb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [1:0]          kind,
	input  wire ucrb_pkg::byte_t     data_byte,
	output ucrb_pkg::rx_mem_t        rx_mem,
	output ucrb_pkg::tx_mem_t        tx_mem,
	output ucrb_pkg::res_flags_t     flags
);

	ucrb_pkg::rx_ptr_t rx_wp_q, rx_rp_q, rx_wp_d, rx_rp_d, rx_wp_nx, rx_rp_nx;
	ucrb_pkg::tx_ptr_t tx_wp_q, tx_rp_q, tx_wp_d, tx_rp_d, tx_wp_nx, tx_rp_nx;
	logic              tx_en_q, tx_en_d;
	ucrb_pkg::kind_t   kind_c;

	assign kind_c   = ucrb_pkg::kind_t'(kind);
	assign rx_wp_nx = ucrb_pkg::rx_next(rx_wp_q);
	assign rx_rp_nx = ucrb_pkg::rx_next(rx_rp_q);
	assign tx_wp_nx = ucrb_pkg::tx_next(tx_wp_q);
	assign tx_rp_nx = ucrb_pkg::tx_next(tx_rp_q);

	always_comb begin
		rx_wp_d = rx_wp_q;
		rx_rp_d = rx_rp_q;
		tx_wp_d = tx_wp_q;
		tx_rp_d = tx_rp_q;
		tx_en_d = tx_en_q;
		rx_mem  = '0;
		tx_mem  = '0;
		flags   = '0;
		if (accept) begin
			case (kind_c)
				ucrb_pkg::KIND_HOST_WRITE: begin
					// full at depth minus one entries
					if (tx_wp_nx != tx_rp_q) begin
						tx_mem.we            = 1'b1;
						tx_mem.waddr         = tx_wp_q;
						tx_mem.wdata         = data_byte;
						tx_wp_d              = tx_wp_nx;
						tx_en_d              = 1'b1;
						flags.write_accepted = 1'b1;
					end
				end
				ucrb_pkg::KIND_HOST_READ: begin
					if (rx_wp_q != rx_rp_q) begin
						rx_mem.re        = 1'b1;
						rx_mem.raddr     = rx_rp_q;
						rx_rp_d          = rx_rp_nx;
						flags.read_valid = 1'b1;
					end
				end
				ucrb_pkg::KIND_LINE_RX: begin
					// overflow drops the oldest byte
					if (rx_wp_nx == rx_rp_q) begin
						rx_rp_d          = rx_rp_nx;
						flags.rx_dropped = 1'b1;
					end
					rx_mem.we    = 1'b1;
					rx_mem.waddr = rx_wp_q;
					rx_mem.wdata = data_byte;
					rx_wp_d      = rx_wp_nx;
				end
				ucrb_pkg::KIND_TX_READY: begin
					if (tx_en_q) begin
						if (tx_wp_q == tx_rp_q) begin
							tx_en_d = 1'b0;
						end else begin
							tx_mem.re      = 1'b1;
							tx_mem.raddr   = tx_rp_q;
							tx_rp_d        = tx_rp_nx;
							flags.tx_valid = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		flags.tx_irq_enabled = tx_en_d;
		flags.tx_idle        = (tx_wp_d == tx_rp_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wp_q <= '0;
			rx_rp_q <= '0;
			tx_wp_q <= '0;
			tx_rp_q <= '0;
			tx_en_q <= 1'b1;
		end else begin
			rx_wp_q <= rx_wp_d;
			rx_rp_q <= rx_rp_d;
			tx_wp_q <= tx_wp_d;
			tx_rp_q <= tx_rp_d;
			tx_en_q <= tx_en_d;
		end
	end

	`ASSERT_CLK(a_tx_full_holds, accept && kind == ucrb_pkg::KIND_HOST_WRITE && tx_wp_nx == tx_rp_q |=> $stable(tx_wp_q), "host write advanced a full transmit ring")
	`ASSERT_CLK(a_rx_not_empty, accept && kind == ucrb_pkg::KIND_LINE_RX |=> rx_wp_q != rx_rp_q, "receive ring empty right after a line byte")
	`ASSERT_CLK(a_en_fall, $fell(tx_en_q) |-> $past(accept && kind == ucrb_pkg::KIND_TX_READY && tx_wp_q == tx_rp_q), "transmit enable cleared without a ready on an empty ring")

endmodule

`default_nettype wire

// ===== hdl/uart_rx_tx_ring_buffers.sv =====
// top level of the buffered uart transmit and receive rings
//
// channel   direction  handshake                     payload
// command   in         start high while busy low     kind, data_byte, end_of_burst
// result    out        done high for one cycle       write_accepted .. rx_dropped
//
// one item every cycle: the item is decoded and its pointer update and store
// access happen on the accept edge, and the result shows on done in the next cycle,
// when the store read data is out of its registered read port.
// busy never rises, so the next item can follow directly behind.
// reset clears pointers and done and sets the transmit enable; store
// contents are not reset and only entries between read and write pointer are read.
// the result side has no stall, each item is on the ports for exactly one cycle.
`default_nettype none

module uart_rx_tx_ring_buffers (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_burst,
	output logic            done,
	output logic            write_accepted,
	output logic            read_valid,
	output logic [7:0]      read_data,
	output logic            tx_valid,
	output logic [7:0]      tx_data,
	output logic            tx_irq_enabled,
	output logic            tx_idle,
	output logic            rx_dropped
);

	logic                 accept;
	ucrb_pkg::rx_mem_t    rx_mem;
	ucrb_pkg::tx_mem_t    tx_mem;
	ucrb_pkg::res_flags_t flags;
	ucrb_pkg::res_flags_t flags_q;
	logic                 done_q;
	ucrb_pkg::byte_t      rx_rdata;
	ucrb_pkg::byte_t      tx_rdata;
	logic                 burst_end_q;

	// busy is tied low, the stores never need an item held off
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// pointer bookkeeping and store commands
	ucrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.data_byte (data_byte),
		.rx_mem    (rx_mem),
		.tx_mem    (tx_mem),
		.flags     (flags)
	);

	// receive ring store
	ucrb_ram #(
		.DEPTH (ucrb_pkg::RX_DEPTH),
		.WIDTH (8)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_mem.we),
		.waddr (rx_mem.waddr),
		.wdata (rx_mem.wdata),
		.re    (rx_mem.re),
		.raddr (rx_mem.raddr),
		.rdata (rx_rdata)
	);

	// transmit ring store
	ucrb_ram #(
		.DEPTH (ucrb_pkg::TX_DEPTH),
		.WIDTH (8)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_mem.we),
		.waddr (tx_mem.waddr),
		.wdata (tx_mem.wdata),
		.re    (tx_mem.re),
		.raddr (tx_mem.raddr),
		.rdata (tx_rdata)
	);

	// result register, lines up with the registered store reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			flags_q <= '0;
		end else begin
			done_q  <= accept;
			flags_q <= flags;
		end
	end

	// burst marker has no effect on the rings, kept only as item history
	always_ff @(posedge clk) begin
		if (accept) begin
			burst_end_q <= end_of_burst;
		end
	end

	assign done           = done_q;
	assign write_accepted = flags_q.write_accepted;
	assign read_valid     = flags_q.read_valid;
	// data fields read as zero when their valid flag is low
	assign read_data      = flags_q.read_valid ? rx_rdata : 8'h00;
	assign tx_valid       = flags_q.tx_valid;
	assign tx_data        = (flags_q.tx_valid || (burst_end_q && 1'b0)) ? tx_rdata : 8'h00;
	assign tx_irq_enabled = flags_q.tx_irq_enabled;
	assign tx_idle        = flags_q.tx_idle;
	assign rx_dropped     = flags_q.rx_dropped;

endmodule

`default_nettype wire
